// ===== src/lbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the latency budget controller
// Word layouts, register indexes, operation codes and fixed-point constants.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMA_ALPHA       = 3'd0,
    CFG_BASE_OPS        = 3'd1,
    CFG_TARGET_LATENCY  = 3'd2,
    CFG_HEADROOM        = 3'd3,
    CFG_LOAD_HARD_LIMIT = 3'd4,
    CFG_LOAD_SOFT_LIMIT = 3'd5,
    CFG_HOT_FLOOR_OPS   = 3'd6,
    CFG_MIN_OPS         = 3'd7
  } lbc_cfg_e;

  typedef enum logic [1:0] {
    OP_OBSERVE  = 2'd0,
    OP_SET_LOAD = 2'd1,
    OP_QUERY    = 2'd2
  } lbc_op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [23:0] latency_sample;
    logic [15:0] load_sample;
    logic        hot_query;
  } lbc_in_t;

  typedef struct packed {
    logic [31:0] op_quota;
    logic [23:0] batch_quota;
    logic        refine_allowed;
    logic        tight;
  } lbc_out_t;

  // request to and response from the divide / square root unit
  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [23:0] divisor;
  } lbc_root_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] root;
  } lbc_root_rsp_t;

  // register reset values
  localparam logic [16:0] AlphaReset    = 17'd6554;
  localparam logic [23:0] BaseOpsReset  = 24'd2000;
  localparam logic [23:0] TargetReset   = 24'd2560;
  localparam logic [15:0] HeadroomReset = 16'd384;
  localparam logic [14:0] HardReset     = 15'd23040;
  localparam logic [14:0] SoftReset     = 15'd17920;
  localparam logic [23:0] HotFloorReset = 24'd500;
  localparam logic [23:0] MinOpsReset   = 24'd100;

  // fixed-point constants
  localparam logic [16:0] AlphaOne      = 17'h10000;  // 1.0 in Q0.16
  localparam logic [16:0] AlphaDefault  = 17'd6554;   // 0.1 in Q0.16
  localparam logic [14:0] LoadMax       = 15'd25600;  // 100 percent
  localparam logic [15:0] SoftFactor    = 16'd39322;  // 0.6 in Q0.16
  localparam int          BucketDiv     = 500;
  localparam int          RecipShift    = 40;
  localparam logic [31:0] BucketRecip   = 32'd2199023255;  // floor(2^40 / 500)
  localparam int          RefineMarginMs = 1;
  localparam logic [24:0] RefineMargin  = 25'(RefineMarginMs * 256);

endpackage

// ===== src/lbc_root_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_root_unit: iterative sqrt of a scaled quotient
// Computes floor(sqrt(floor(dividend * 2^32 / divisor))) with one shared
// subtractor: 32 restoring divide steps, then 16 square root steps.
// ----------------------------------------------------------------------------
module lbc_root_unit
  import lbc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lbc_root_req_t req_i,
  output lbc_root_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_DIV,
    P_SQRT
  } phase_e;

  phase_e      phase_q;
  logic [4:0]  count_q;
  logic [23:0] rem_q, rem_d;
  logic [23:0] divisor_q;
  logic [31:0] work_q, work_d;
  logic [15:0] root_q, root_d;
  logic        done_q;

  logic [25:0] sub_a, sub_b;
  logic [26:0] diff;
  logic        borrow;

  // shared subtractor, operands set by phase
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (phase_q)
      P_DIV: begin
        sub_a = {1'b0, rem_q, 1'b0};
        sub_b = {2'b00, divisor_q};
      end
      P_SQRT: begin
        sub_a = {6'b0, rem_q[17:0], work_q[31:30]};
        sub_b = {8'b0, root_q, 2'b01};
      end
      default: begin
      end
    endcase
    diff   = {1'b0, sub_a} - {1'b0, sub_b};
    borrow = diff[26];
  end

  always_comb begin
    rem_d  = rem_q;
    work_d = work_q;
    root_d = root_q;
    case (phase_q)
      P_DIV: begin
        rem_d  = borrow ? sub_a[23:0] : diff[23:0];
        work_d = {work_q[30:0], ~borrow};
      end
      P_SQRT: begin
        rem_d  = {6'b0, (borrow ? sub_a[17:0] : diff[17:0])};
        work_d = {work_q[29:0], 2'b00};
        root_d = {root_q[14:0], ~borrow};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= P_IDLE;
      count_q   <= '0;
      rem_q     <= '0;
      divisor_q <= '0;
      work_q    <= '0;
      root_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      // pulse after the last root step
      done_q <= (phase_q == P_SQRT) && (count_q == '0);
      case (phase_q)
        P_IDLE: begin
          if (req_i.start) begin
            rem_q     <= req_i.dividend;
            divisor_q <= req_i.divisor;
            work_q    <= '0;
            count_q   <= 5'd31;
            phase_q   <= P_DIV;
          end
        end
        P_DIV: begin
          work_q <= work_d;
          if (count_q == '0) begin
            // quotient complete: restart the remainder for the root
            rem_q   <= '0;
            root_q  <= '0;
            count_q <= 5'd15;
            phase_q <= P_SQRT;
          end else begin
            rem_q   <= rem_d;
            count_q <= count_q - 5'd1;
          end
        end
        P_SQRT: begin
          rem_q   <= rem_d;
          work_q  <= work_d;
          root_q  <= root_d;
          count_q <= count_q - 5'd1;
          if (count_q == '0) begin
            phase_q <= P_IDLE;
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ===== src/latency_budget_controller_core.sv =====
`timescale 1ns / 1ps
// Query path: over target a query waits on the root unit (32 divide and 16
// root steps); a load at or above the soft limit but under the hard one adds
// S_SOFT. An observe seeds a zero average, else runs S_OBS_A, S_OBS_B, S_OBS_C.
// Throughput: one word at a time; the next word is taken the cycle after the
// result register loads, so a waiting result holds the core.
// Reset: asynchronous, active low; registers to defaults, average and load zero.
// ----------------------------------------------------------------------------
// latency_budget_controller_core: adaptive work-budget controller
// Sequencer around a shared multiplier and an iterative divide/root unit.
// ----------------------------------------------------------------------------
module latency_budget_controller_core
  import lbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbc_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbc_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OBS_A,
    S_OBS_B,
    S_OBS_C,
    S_Q_START,
    S_ROOT,
    S_LOAD,
    S_SOFT,
    S_BASE,
    S_CAP,
    S_RND,
    S_RECIP,
    S_QEST,
    S_FIX
  } state_e;

  // configuration
  logic [16:0] alpha_q;
  logic [23:0] base_q, target_q, hot_floor_q, min_ops_q;
  logic [15:0] headroom_q;
  logic [14:0] hard_q, soft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= AlphaReset;
      base_q      <= BaseOpsReset;
      target_q    <= TargetReset;
      headroom_q  <= HeadroomReset;
      hard_q      <= HardReset;
      soft_q      <= SoftReset;
      hot_floor_q <= HotFloorReset;
      min_ops_q   <= MinOpsReset;
    end else if (cfg_we_i) begin
      case (lbc_cfg_e'(cfg_index_i))
        CFG_EMA_ALPHA:       alpha_q     <= cfg_data_i[16:0];
        CFG_BASE_OPS:        base_q      <= cfg_data_i;
        CFG_TARGET_LATENCY:  target_q    <= cfg_data_i;
        CFG_HEADROOM:        headroom_q  <= cfg_data_i[15:0];
        CFG_LOAD_HARD_LIMIT: hard_q      <= cfg_data_i[14:0];
        CFG_LOAD_SOFT_LIMIT: soft_q      <= cfg_data_i[14:0];
        CFG_HOT_FLOOR_OPS:   hot_floor_q <= cfg_data_i;
        CFG_MIN_OPS:         min_ops_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  state_e      state_q;
  lbc_in_t     item_q;
  logic [23:0] avg_q;
  logic [14:0] load_q;
  logic [23:0] scale_q;
  logic [63:0] product_q;
  logic [40:0] acc_q;
  logic [47:0] ops_q;
  logic [31:0] r_q;
  logic [23:0] q_q;
  logic        refine_q, tight_q;
  logic        out_valid_q;
  lbc_out_t    out_data_q;

  lbc_root_req_t root_req;
  lbc_root_rsp_t root_rsp;

  lbc_root_unit u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  logic        in_accept;
  logic [16:0] alpha_eff, alpha_rest;
  logic [23:0] ema_w;
  logic        over_w, hard_w, soft_w;
  logic [14:0] load_clamped;
  logic [40:0] obs_sum;
  logic [24:0] hard_sum;
  logic [40:0] soft_sum;
  logic [47:0] floor_w, cap_w, ops_min;
  logic [48:0] rnd_sum;
  logic [31:0] r_w;
  logic [31:0] rem_w;
  logic [23:0] q_fix, bucket_w;
  logic        out_free;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    alpha_eff    = (alpha_q == '0 || alpha_q > AlphaOne) ? AlphaDefault : alpha_q;
    alpha_rest   = AlphaOne - alpha_eff;
    ema_w        = (avg_q != '0) ? avg_q : target_q;
    over_w       = ema_w > target_q;
    hard_w       = load_q >= hard_q;
    soft_w       = load_q >= soft_q;
    load_clamped = (in_data_i.load_sample > {1'b0, LoadMax}) ? LoadMax
                                                             : in_data_i.load_sample[14:0];
    obs_sum      = acc_q + product_q[40:0] + 41'd32768;
    hard_sum     = {1'b0, scale_q} + 25'd2;
    soft_sum     = product_q[40:0] + 41'd32768;
    floor_w      = {8'b0, (item_q.hot_query ? hot_floor_q : min_ops_q), 16'b0};
    cap_w        = {product_q[39:0], 8'b0};
    ops_min      = (ops_q > cap_w) ? cap_w : ops_q;
    rnd_sum      = {1'b0, ops_min} + 49'd32768;
    // saturate, then hold at least one
    if (rnd_sum[48]) begin
      r_w = '1;
    end else if (rnd_sum[47:16] == '0) begin
      r_w = 32'd1;
    end else begin
      r_w = rnd_sum[47:16];
    end
    rem_w    = r_q - product_q[31:0];
    q_fix    = (rem_w >= 32'(BucketDiv)) ? q_q + 24'd1 : q_q;
    bucket_w = (q_fix == '0) ? 24'd1 : q_fix;
    out_free = !out_valid_q || !out_stall_i;
  end

  assign root_req.start    = (state_q == S_Q_START) && over_w;
  assign root_req.dividend = target_q;
  assign root_req.divisor  = ema_w;

  // shared multiplier operand select
  logic        mul_en;
  logic [31:0] mul_a, mul_b;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_OBS_A: begin
        mul_en = 1'b1;
        mul_a  = {15'b0, alpha_eff};
        mul_b  = {8'b0, item_q.latency_sample};
      end
      S_OBS_B: begin
        mul_en = 1'b1;
        mul_a  = {15'b0, alpha_rest};
        mul_b  = {8'b0, avg_q};
      end
      S_LOAD: begin
        mul_en = !hard_w && soft_w;
        mul_a  = {8'b0, scale_q};
        mul_b  = {16'b0, SoftFactor};
      end
      S_BASE: begin
        mul_en = 1'b1;
        mul_a  = {8'b0, base_q};
        mul_b  = {8'b0, scale_q};
      end
      S_CAP: begin
        mul_en = 1'b1;
        mul_a  = {8'b0, base_q};
        mul_b  = {16'b0, headroom_q};
      end
      S_RECIP: begin
        mul_en = 1'b1;
        mul_a  = r_q;
        mul_b  = BucketRecip;
      end
      S_QEST: begin
        mul_en = 1'b1;
        mul_a  = {8'b0, product_q[63:RecipShift]};
        mul_b  = 32'(BucketDiv);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      avg_q       <= '0;
      load_q      <= '0;
      scale_q     <= '0;
      product_q   <= '0;
      acc_q       <= '0;
      ops_q       <= '0;
      r_q         <= '0;
      q_q         <= '0;
      refine_q    <= 1'b0;
      tight_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (mul_en) begin
        product_q <= mul_a * mul_b;
      end
      // the final query step loads the result register itself
      if (out_valid_q && !out_stall_i && state_q != S_FIX) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            item_q <= in_data_i;
            case (in_data_i.operation)
              OP_OBSERVE: begin
                if (avg_q == '0) begin
                  avg_q <= in_data_i.latency_sample;
                end else begin
                  state_q <= S_OBS_A;
                end
              end
              OP_SET_LOAD: load_q  <= load_clamped;
              OP_QUERY:    state_q <= S_Q_START;
              default: begin
              end
            endcase
          end
        end
        S_OBS_A: state_q <= S_OBS_B;
        S_OBS_B: begin
          acc_q   <= product_q[40:0];
          state_q <= S_OBS_C;
        end
        S_OBS_C: begin
          avg_q   <= obs_sum[39:16];
          state_q <= S_IDLE;
        end
        S_Q_START: begin
          refine_q <= (({1'b0, ema_w} + RefineMargin) < {1'b0, target_q}) && !soft_w;
          tight_q  <= over_w || soft_w;
          if (over_w) begin
            state_q <= S_ROOT;
          end else begin
            scale_q <= {headroom_q, 8'b0};
            state_q <= S_LOAD;
          end
        end
        S_ROOT: begin
          if (root_rsp.done) begin
            scale_q <= {8'b0, root_rsp.root};
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (hard_w) begin
            scale_q <= {1'b0, hard_sum[24:2]};
            state_q <= S_BASE;
          end else if (soft_w) begin
            state_q <= S_SOFT;
          end else begin
            state_q <= S_BASE;
          end
        end
        S_SOFT: begin
          scale_q <= soft_sum[39:16];
          state_q <= S_BASE;
        end
        S_BASE: state_q <= S_CAP;
        S_CAP: begin
          // raise to the floor
          ops_q   <= (product_q[47:0] < floor_w) ? floor_w : product_q[47:0];
          state_q <= S_RND;
        end
        S_RND: begin
          r_q     <= r_w;
          state_q <= S_RECIP;
        end
        S_RECIP: state_q <= S_QEST;
        S_QEST: begin
          q_q     <= product_q[63:RecipShift];
          state_q <= S_FIX;
        end
        S_FIX: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q                <= 1'b1;
            out_data_q.op_quota        <= r_q;
            out_data_q.batch_quota     <= bucket_w;
            out_data_q.refine_allowed  <= refine_q;
            out_data_q.tight           <= tight_q;
            state_q                    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_root_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_rsp.done |-> state_q == S_ROOT)
    else $error("root unit finished outside of a query");

  a_budget_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.op_quota != '0 && out_data_o.batch_quota != '0))
    else $error("budget word carries a zero budget");

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIX))
    else $error("result word raised outside the final query step");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.operation == OP_QUERY) |=>
      state_q == S_Q_START)
    else $error("accepted query did not start");
`endif

endmodule
